// File: hw/rtl/asgr_pkg.sv
package asgr_pkg;

    localparam int ATTR_W = 16;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_M = 8'h6d;
    localparam logic [7:0] CH_K = 8'h4b;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [ATTR_W-1:0] BASE_RESET = ATTR_W'(7);

    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_BASE = 3'd4;

    typedef enum logic [1:0] {
        EV_TEXT  = 2'd0,
        EV_ATTR  = 2'd1,
        EV_ERASE = 2'd2
    } t_ev;

    typedef struct packed {
        t_ev               kind;
        logic [7:0]        text;
        logic [ATTR_W-1:0] attr;
        logic              esc_first;
    } t_entry;

endpackage

// File: hw/rtl/ansi_sgr_escape_parser.sv
// ANSI SGR escape parser: takes one byte of a text stream per cycle on the slave
// side if its queue has room, gives text, set-attribute and erase-to-end-of-line
// transfers on the master side, tlast marking the final result of each byte. A
// byte is parsed in the cycle it is accepted; its results wait in a four-entry
// queue before the output register, so input keeps flowing while the output
// stalls, until the queue fills. A lone ESC followed by another byte gives two
// results. The user must write emulation_enable (address 0) and base_attribute
// (address 4) over the APB port only while the stream is idle; it is not checked.
module ansi_sgr_escape_parser import asgr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // byte_in[7:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // event_res[1:0], text_byte[9:2], attribute[25:10], zero
    output logic        o_m_tlast,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic              r_en;
    logic [ATTR_W-1:0] r_base;
    logic              wr;
    logic              push, pop, full, empty;
    t_entry            entry, head;

    assign o_pready = 1'b1;
    assign wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b1;
            r_base <= BASE_RESET;
        end else if (wr) begin
            if (i_paddr == ADDR_ENABLE) begin
                r_en <= i_pwdata[0];
            end else if (i_paddr == ADDR_BASE) begin
                r_base <= i_pwdata[ATTR_W-1:0];
            end
        end
    end

    always_comb begin
        case (i_paddr)
            ADDR_ENABLE: o_prdata = {31'd0, r_en};
            ADDR_BASE:   o_prdata = {(32 - ATTR_W)'(0), r_base};
            default:     o_prdata = 32'd0;
        endcase
    end

    asgr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_en    (r_en),
        .i_base  (r_base),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    asgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    asgr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// File: hw/rtl/asgr_front.sv
module asgr_front import asgr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_en,
    input  logic [ATTR_W-1:0] i_base,
    input  logic              i_full,
    output logic              o_push,
    output t_entry            o_entry
);

    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_ESC  = 3'b010,
        PH_CSI  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic              neg;
    } t_shadow;

    t_phase            r_phase, n_phase;
    logic [7:0]        r_acc, n_acc;
    logic [ATTR_W-1:0] r_cattr, n_cattr;
    logic              r_cneg, n_cneg;
    logic [ATTR_W-1:0] r_sattr, n_sattr;
    logic              r_sneg, n_sneg;

    logic              accept;
    logic              is_digit;
    logic [11:0]       acc_sum;
    t_shadow           applied;
    logic [ATTR_W-1:0] eff;

    function automatic t_shadow apply_code(input logic [7:0] v, input logic [ATTR_W-1:0] a_in,
                                           input logic neg_in, input logic [ATTR_W-1:0] base);
        t_shadow    r;
        logic [7:0] d;
        r.attr = a_in;
        r.neg  = neg_in;
        d      = 8'd0;
        if (v == 8'd0) begin
            r.attr = base;
            r.neg  = 1'b0;
        end else if (v == 8'd1) begin
            r.attr[3] = 1'b1;
        end else if (v == 8'd2 || v == 8'd22) begin
            r.attr[3] = 1'b0;
        end else if (v == 8'd5 || v == 8'd6) begin
            r.attr[7] = 1'b1;
        end else if (v == 8'd25) begin
            r.attr[7] = 1'b0;
        end else if (v == 8'd7) begin
            r.neg = 1'b1;
        end else if (v == 8'd27) begin
            r.neg = 1'b0;
        end else if (v >= 8'd30 && v <= 8'd37) begin
            d = v - 8'd30;
            r.attr[2:0] = {d[0], d[1], d[2]};
        end else if (v == 8'd39) begin
            r.attr[2:0] = base[2:0];
        end else if (v >= 8'd40 && v <= 8'd47) begin
            d = v - 8'd40;
            r.attr[6:4] = {d[0], d[1], d[2]};
        end else if (v == 8'd49) begin
            r.attr[6:4] = base[6:4];
        end
        return r;
    endfunction

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign acc_sum  = {4'd0, r_acc} * 12'd10 + {8'd0, i_byte[3:0]};
    assign applied  = apply_code(r_acc, r_sattr, r_sneg, i_base);

    always_comb begin
        eff = applied.attr;
        if (applied.neg) begin
            eff[2:0] = applied.attr[6:4];
            eff[6:4] = applied.attr[2:0];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_cattr = r_cattr;
        n_cneg  = r_cneg;
        n_sattr = r_sattr;
        n_sneg  = r_sneg;
        o_push  = 1'b0;
        o_entry = '{kind: EV_TEXT, text: i_byte, attr: '0, esc_first: 1'b0};
        if (accept) begin
            if (!i_en) begin
                n_phase = PH_TEXT;
                o_push  = 1'b1;
            end else begin
                case (r_phase)
                    PH_CSI: begin
                        if (is_digit) begin
                            n_acc = (acc_sum > 12'd255) ? 8'd255 : acc_sum[7:0];
                        end else if (i_byte == CH_SEMI) begin
                            n_sattr = applied.attr;
                            n_sneg  = applied.neg;
                            n_acc   = 8'd0;
                        end else begin
                            if (i_byte == CH_M) begin
                                n_sattr = applied.attr;
                                n_sneg  = applied.neg;
                                n_cattr = applied.attr;
                                n_cneg  = applied.neg;
                                o_push  = 1'b1;
                                o_entry = '{kind: EV_ATTR, text: 8'd0, attr: eff, esc_first: 1'b0};
                            end else if (i_byte == CH_K) begin
                                o_push  = 1'b1;
                                o_entry = '{kind: EV_ERASE, text: 8'd0, attr: '0, esc_first: 1'b0};
                            end
                            n_acc   = 8'd0;
                            n_phase = PH_TEXT;
                        end
                    end
                    PH_ESC: begin
                        if (i_byte == CH_LBRACKET) begin
                            n_phase = PH_CSI;
                            n_acc   = 8'd0;
                            n_sattr = r_cattr;
                            n_sneg  = r_cneg;
                        end else if (i_byte == CH_ESC) begin
                            o_push       = 1'b1;
                            o_entry.text = CH_ESC;
                        end else begin
                            n_phase           = PH_TEXT;
                            o_push            = 1'b1;
                            o_entry.esc_first = 1'b1;
                        end
                    end
                    default: begin
                        if (i_byte == CH_ESC) begin
                            n_phase = PH_ESC;
                        end else begin
                            n_phase = PH_TEXT;
                            o_push  = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_acc   <= 8'd0;
            r_cattr <= BASE_RESET;
            r_cneg  <= 1'b0;
            r_sattr <= BASE_RESET;
            r_sneg  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_cattr <= n_cattr;
            r_cneg  <= n_cneg;
            r_sattr <= n_sattr;
            r_sneg  <= n_sneg;
        end
    end

endmodule

// File: hw/rtl/asgr_queue.sv
module asgr_queue import asgr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wptr, n_wptr;
    logic [Q_AW-1:0]  r_rptr, n_rptr;
    logic [Q_AW:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? r_wptr + Q_AW'(1) : r_wptr;
        n_rptr  = do_pop ? r_rptr + Q_AW'(1) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (Q_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// File: hw/rtl/asgr_back.sv
module asgr_back import asgr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_entry      i_head,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // event_res[1:0], text_byte[9:2], attribute[25:10], zero
    output logic        o_m_tlast
);

    logic              r_valid, n_valid;
    logic              r_second, n_second;
    t_ev               r_kind, n_kind;
    logic [7:0]        r_text, n_text;
    logic [ATTR_W-1:0] r_attr, n_attr;
    logic              r_last, n_last;
    logic              load;

    assign load = !r_valid || i_m_tready;

    always_comb begin
        n_valid  = r_valid;
        n_second = r_second;
        n_kind   = r_kind;
        n_text   = r_text;
        n_attr   = r_attr;
        n_last   = r_last;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                if (i_head.esc_first && !r_second) begin
                    // emit the held ESC first, keep the entry for its byte
                    n_kind   = EV_TEXT;
                    n_text   = CH_ESC;
                    n_attr   = '0;
                    n_last   = 1'b0;
                    n_second = 1'b1;
                end else begin
                    n_kind   = i_head.kind;
                    n_text   = i_head.text;
                    n_attr   = i_head.attr;
                    n_last   = 1'b1;
                    n_second = 1'b0;
                    o_pop    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_text <= n_text;
        r_attr <= n_attr;
        r_last <= n_last;
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {(32 - 10 - ATTR_W)'(0), r_attr, r_text, r_kind};
    assign o_m_tlast  = r_last;

endmodule

// File: bench/tb_top.sv
module tb_top;
    import asgr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES = 400;

    localparam logic [ATTR_W-1:0] FG_MASK   = ATTR_W'(16'h0007);
    localparam logic [ATTR_W-1:0] BG_MASK   = ATTR_W'(16'h0070);
    localparam logic [ATTR_W-1:0] FG_BRIGHT = ATTR_W'(16'h0008);
    localparam logic [ATTR_W-1:0] BG_BRIGHT = ATTR_W'(16'h0080);

    localparam int SGR_RESET       = 0;
    localparam int SGR_BOLD        = 1;
    localparam int SGR_FAINT       = 2;
    localparam int SGR_BLINK       = 5;
    localparam int SGR_BLINK_FAST  = 6;
    localparam int SGR_REVERSE     = 7;
    localparam int SGR_NORMAL      = 22;
    localparam int SGR_BLINK_OFF   = 25;
    localparam int SGR_REVERSE_OFF = 27;
    localparam int SGR_FG_FIRST    = 30;
    localparam int SGR_FG_LAST     = 36;
    localparam int SGR_FG_WHITE    = 37;
    localparam int SGR_FG_DEFAULT  = 39;
    localparam int SGR_BG_FIRST    = 40;
    localparam int SGR_BG_LAST     = 46;
    localparam int SGR_BG_WHITE    = 47;
    localparam int SGR_BG_DEFAULT  = 49;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2
    } t_parse_ph;

    typedef struct packed {
        t_ev               kind;
        logic [7:0]        text;
        logic [ATTR_W-1:0] attr;
        logic              last;
    } t_sgr_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // byte_in[7:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;           // event_res[1:0], text_byte[9:2], attribute[25:10], zero
    logic        o_m_tlast;
    logic        i_psel = 1'b0;
    logic        i_penable = 1'b0;
    logic        i_pwrite = 1'b0;
    logic [2:0]  i_paddr = 3'd0;
    logic [31:0] i_pwdata = 32'h0;
    logic [31:0] o_prdata;
    logic        o_pready;

    ansi_sgr_escape_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // parser mirror
    logic              cfg_enable = 1'b1;
    logic [ATTR_W-1:0] cfg_base = BASE_RESET;
    t_parse_ph         ph = PH_TEXT;
    logic [7:0]        code_acc = 8'd0;
    logic [ATTR_W-1:0] com_attr = BASE_RESET;
    logic              com_neg = 1'b0;
    logic [ATTR_W-1:0] sh_attr = BASE_RESET;
    logic              sh_neg = 1'b0;

    logic [7:0] tx_bytes[$];
    t_sgr_event expected_events[$];
    t_sgr_event want;

    int  mismatches = 0;
    int  cycle_cnt = 0;
    bit  byte_taken = 0;
    bit  res_taken = 0;
    int  src_wait = 0;
    bit  src_burst = 0;
    int  sink_wait = 0;
    bit  sink_burst = 0;
    bit  hold_req = 0;
    int  hold_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void check_field(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
            mismatches++;
        end
    endfunction

    function automatic void apply_sgr(input logic [7:0] code);
        logic [ATTR_W-1:0] a;
        logic [7:0]        k;
        a = sh_attr;
        if (code == SGR_RESET) begin
            a = cfg_base;
            sh_neg = 1'b0;
        end else if (code == SGR_BOLD) begin
            a = a | FG_BRIGHT;
        end else if (code == SGR_FAINT || code == SGR_NORMAL) begin
            a = a & ~FG_BRIGHT;
        end else if (code == SGR_BLINK || code == SGR_BLINK_FAST) begin
            a = a | BG_BRIGHT;
        end else if (code == SGR_BLINK_OFF) begin
            a = a & ~BG_BRIGHT;
        end else if (code == SGR_REVERSE) begin
            sh_neg = 1'b1;
        end else if (code == SGR_REVERSE_OFF) begin
            sh_neg = 1'b0;
        end else if (code >= SGR_FG_FIRST && code <= SGR_FG_LAST) begin
            k = code - 8'(SGR_FG_FIRST);
            a[2:0] = {k[0], k[1], k[2]};
        end else if (code == SGR_FG_WHITE) begin
            a = a | FG_MASK;
        end else if (code == SGR_FG_DEFAULT) begin
            a = (a & ~FG_MASK) | (cfg_base & FG_MASK);
        end else if (code >= SGR_BG_FIRST && code <= SGR_BG_LAST) begin
            k = code - 8'(SGR_BG_FIRST);
            a[6:4] = {k[0], k[1], k[2]};
        end else if (code == SGR_BG_WHITE) begin
            a = a | BG_MASK;
        end else if (code == SGR_BG_DEFAULT) begin
            a = (a & ~BG_MASK) | (cfg_base & BG_MASK);
        end
        sh_attr = a;
    endfunction

    function automatic logic [ATTR_W-1:0] shown_attr();
        logic [ATTR_W-1:0] a;
        a = com_attr;
        if (com_neg)
            a = {a[ATTR_W-1:7], a[2:0], a[3], a[6:4]};
        return a;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        t_sgr_event ev[2];
        int         n;
        int         acc;
        n = 0;
        if (!cfg_enable) begin
            ph = PH_TEXT;
            ev[n] = '{kind: EV_TEXT, text: b, attr: '0, last: 1'b0};
            n++;
        end else if (ph == PH_CSI) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                acc = int'(code_acc) * 10 + int'(b - CH_ZERO);
                code_acc = (acc > 255) ? 8'd255 : acc[7:0];
            end else if (b == CH_SEMI) begin
                apply_sgr(code_acc);
                code_acc = 8'd0;
            end else begin
                if (b == CH_M) begin
                    apply_sgr(code_acc);
                    com_attr = sh_attr;
                    com_neg = sh_neg;
                    ev[n] = '{kind: EV_ATTR, text: 8'h00, attr: shown_attr(), last: 1'b0};
                    n++;
                end else if (b == CH_K) begin
                    ev[n] = '{kind: EV_ERASE, text: 8'h00, attr: '0, last: 1'b0};
                    n++;
                end
                code_acc = 8'd0;
                ph = PH_TEXT;
            end
        end else if (ph == PH_ESC && b == CH_LBRACKET) begin
            ph = PH_CSI;
            code_acc = 8'd0;
            sh_attr = com_attr;
            sh_neg = com_neg;
        end else begin
            if (ph == PH_ESC) begin
                ev[n] = '{kind: EV_TEXT, text: CH_ESC, attr: '0, last: 1'b0};
                n++;
            end
            if (b == CH_ESC) begin
                ph = PH_ESC;
            end else begin
                ph = PH_TEXT;
                ev[n] = '{kind: EV_TEXT, text: b, attr: '0, last: 1'b0};
                n++;
            end
        end
        if (n > 0)
            ev[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_events.push_back(ev[i]);
    endfunction

    // monitor: transfers on both sides, sampled at the rising edge
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                res_taken = 1;
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected transfer: expected none, actual tdata %h tlast %b",
                             $time, o_m_tdata, o_m_tlast);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event", 32'(want.kind), 32'(o_m_tdata[1:0]));
                    check_field("text", 32'(want.text), 32'(o_m_tdata[9:2]));
                    check_field("attribute", 32'(want.attr), 32'(o_m_tdata[25:10]));
                    check_field("padding", 32'h0, 32'(o_m_tdata[31:26]));
                    check_field("tlast", 32'(want.last), 32'(o_m_tlast));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                byte_taken = 1;
                parse_byte(i_s_tdata);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // byte driver
    always @(negedge i_clk) begin
        if (!i_s_tvalid || byte_taken) begin
            if (src_wait > 0) begin
                src_wait--;
                i_s_tvalid <= 1'b0;
            end else if (tx_bytes.size() > 0) begin
                i_s_tdata <= tx_bytes.pop_front();
                i_s_tvalid <= 1'b1;
                if ($urandom_range(0, 19) == 0)
                    src_burst = !src_burst;
                src_wait = src_burst ? 0 : $urandom_range(0, 13);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        byte_taken = 0;
    end

    // result sink
    always @(negedge i_clk) begin
        if (res_taken) begin
            if ($urandom_range(0, 19) == 0)
                sink_burst = !sink_burst;
            sink_wait = sink_burst ? 0 : $urandom_range(0, 13);
        end else if (sink_wait > 0) begin
            sink_wait--;
        end
        i_m_tready <= (sink_wait == 0) && (hold_left == 0);
        res_taken = 0;
    end

    function automatic void queue_char(input logic [7:0] c);
        tx_bytes.push_back(c);
    endfunction

    function automatic void queue_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            tx_bytes.push_back(s[i]);
    endfunction

    function automatic int pick_sgr_code();
        case ($urandom_range(0, 15))
            0: return SGR_RESET;
            1: return SGR_BOLD;
            2: return SGR_FAINT;
            3: return SGR_NORMAL;
            4: return SGR_BLINK;
            5: return SGR_BLINK_FAST;
            6: return SGR_BLINK_OFF;
            7: return SGR_REVERSE;
            8: return SGR_REVERSE_OFF;
            9, 10: return SGR_FG_FIRST + $urandom_range(0, SGR_FG_LAST - SGR_FG_FIRST);
            11: return SGR_FG_WHITE;
            12: return SGR_FG_DEFAULT;
            13: return SGR_BG_FIRST + $urandom_range(0, SGR_BG_LAST - SGR_BG_FIRST);
            14: return SGR_BG_WHITE;
            default: return SGR_BG_DEFAULT;
        endcase
    endfunction

    function automatic void queue_random(input int count);
        int start;
        int pick;
        int n_codes;
        int fin;
        start = tx_bytes.size();
        while (tx_bytes.size() - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                queue_char(CH_ESC);
                queue_char(CH_LBRACKET);
                n_codes = $urandom_range(0, 4);
                for (int k = 0; k < n_codes; k++) begin
                    if (k > 0)
                        queue_char(CH_SEMI);
                    fin = $urandom_range(0, 9);
                    if (fin < 6)
                        queue_chars($sformatf("%0d", pick_sgr_code()));
                    else if (fin < 8)
                        queue_chars($sformatf("%03d", $urandom_range(0, 99)));
                    else if (fin < 9)
                        queue_chars($sformatf("%0d", $urandom_range(100, 99999)));
                end
                fin = $urandom_range(0, 99);
                if (fin < 82)
                    queue_char(CH_M);
                else if (fin < 90)
                    queue_char(CH_K);
                else
                    queue_char(8'($urandom_range(0, 255)));
            end else if (pick < 58) begin
                queue_char(CH_ESC);
                queue_char(8'($urandom_range(0, 255)));
            end else begin
                queue_char(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || i_s_tvalid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] readback;
        @(negedge i_clk);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= addr;
        i_pwdata <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        if (addr == ADDR_ENABLE)
            cfg_enable = data[0];
        else if (addr == ADDR_BASE)
            cfg_base = data[ATTR_W-1:0];
        readback = (addr == ADDR_ENABLE) ? 32'(cfg_enable) : 32'(cfg_base);
        @(negedge i_clk);
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        check_field("prdata", readback, o_prdata);
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_char(8'h00);
        queue_char(8'hFF);
        queue_char(CH_ESC);
        queue_chars("[;7m");
        queue_char(CH_ESC);
        queue_chars("[K");
        queue_char(CH_ESC);
        queue_chars("x");
        queue_char(CH_ESC);
        queue_char(CH_ESC);
        queue_chars("[999q");
        queue_char(CH_ESC);
        queue_chars("[m");
        wait_drained();

        // stall the sink long enough to back the stream up
        hold_req = 1;
        queue_random(120);
        queue_char(CH_ESC);
        wait_drained();

        cfg_write(ADDR_BASE, 32'h0000_FFFF);
        queue_random(100);
        wait_drained();

        cfg_write(ADDR_BASE, 32'h0000_0000);
        queue_random(80);
        // leave a sequence open across the disable
        queue_char(CH_ESC);
        queue_chars("[3");
        wait_drained();

        cfg_write(ADDR_ENABLE, 32'h0000_0000);
        queue_random(60);
        wait_drained();

        cfg_write(ADDR_ENABLE, 32'h0000_0001);
        cfg_write(ADDR_BASE, 32'($urandom_range(0, 65535)));
        queue_random(90);
        wait_drained();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/asgr_pkg.sv
hw/rtl/asgr_front.sv
hw/rtl/asgr_queue.sv
hw/rtl/asgr_back.sv
hw/rtl/ansi_sgr_escape_parser.sv
bench/tb_top.sv
